// ===== sv/fqsd_pkg.sv =====
// Shared types and codes for the handle queue with delete by key.
package fqsd_pkg;

	typedef enum logic [2:0] {
		REQ_APPEND = 3'd0,
		REQ_INSERT = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_QUERY  = 3'd3,
		REQ_DELETE = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_POP   = 4'b0010,
		S_SCAN  = 4'b0100,
		S_SHIFT = 4'b1000
	} state_t;

endpackage

// ===== sv/fifo_queue_search_delete.sv =====
// Top level: ordered handle queue with append, insert, remove, query and delete by key.
//
// A request is taken when start is high and busy is low; its single result shows on the
// result ports for one cycle with done high, and the receiver has no way to hold it off.
// Append, insert, a refused request and an unused code give their result in the cycle
// after the request; remove reads the head handle and answers from S_POP. Query walks the
// stored handles from the head through the one read port of the entry memory, one handle
// per cycle. Delete walks to the first match and then moves every later handle one place
// toward the head, one per cycle through the same read and write ports. For remove, query
// and delete, busy stays high until the result is out.
module fifo_queue_search_delete #(
	parameter int CAPACITY    = 16,
	parameter int HANDLE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     req_type,
	input  logic [HANDLE_BITS-1:0]         obj_value,
	output logic                           done,
	output logic [HANDLE_BITS-1:0]         obj_out,
	output logic [1:0]                     status,
	output logic                           found,
	output logic [$clog2(CAPACITY+1)-1:0]  queue_length,
	output logic                           is_empty
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	fqsd_pkg::state_t state_q, state_d;
	logic [IW-1:0]          head_q, head_d, head_inc, head_dec;
	logic [CW-1:0]          count_q, count_d;
	logic [CW-1:0]          rd_pos_q, rd_pos_d;
	logic [CW-1:0]          pos_s1;
	logic                   vld_s1, vld_d;
	logic [2:0]             req_q;
	logic [HANDLE_BITS-1:0] h_q;

	logic                   we, re;
	logic [IW-1:0]          waddr, raddr;
	logic [HANDLE_BITS-1:0] wdata, rdata;

	logic                   accept, issue, full, empty;
	logic                   res_load;
	logic [HANDLE_BITS-1:0] res_obj;
	logic [1:0]             res_status;
	logic                   res_found;

	logic                   done_q;
	logic [HANDLE_BITS-1:0] obj_out_q;
	logic [1:0]             status_q;
	logic                   found_q;
	logic [CW-1:0]          len_q;
	logic                   empty_q;

	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head, input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = {{(CW + 1 - IW){1'b0}}, head} + {1'b0, pos};
		if (sum >= (CW + 1)'(CAPACITY)) begin
			sum = sum - (CW + 1)'(CAPACITY);
		end
		return sum[IW-1:0];
	endfunction

	fqsd_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(HANDLE_BITS),
		.AW   (IW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign accept   = start && (state_q == fqsd_pkg::S_IDLE);
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign head_inc = (head_q == IW'(CAPACITY - 1)) ? '0 : head_q + IW'(1);
	assign head_dec = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - IW'(1);
	assign issue    = ((state_q == fqsd_pkg::S_SCAN) || (state_q == fqsd_pkg::S_SHIFT))
	                  && (rd_pos_q < count_q);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		count_d    = count_q;
		rd_pos_d   = rd_pos_q;
		vld_d      = 1'b0;
		we         = 1'b0;
		waddr      = '0;
		wdata      = '0;
		re         = 1'b0;
		raddr      = '0;
		res_load   = 1'b0;
		res_obj    = '0;
		res_status = fqsd_pkg::STAT_OK;
		res_found  = 1'b0;
		case (state_q)
			fqsd_pkg::S_IDLE: begin
				if (start) begin
					case (req_type)
						fqsd_pkg::REQ_APPEND: begin
							res_load = 1'b1;
							if (full) begin
								res_status = fqsd_pkg::STAT_FULL;
							end else begin
								we      = 1'b1;
								waddr   = slot_of(head_q, count_q);
								wdata   = obj_value;
								count_d = count_q + CW'(1);
							end
						end
						fqsd_pkg::REQ_INSERT: begin
							res_load = 1'b1;
							if (full) begin
								res_status = fqsd_pkg::STAT_FULL;
							end else begin
								we      = 1'b1;
								waddr   = head_dec;
								wdata   = obj_value;
								head_d  = head_dec;
								count_d = count_q + CW'(1);
							end
						end
						fqsd_pkg::REQ_REMOVE: begin
							if (empty) begin
								res_load   = 1'b1;
								res_status = fqsd_pkg::STAT_EMPTY;
							end else begin
								re      = 1'b1;
								raddr   = head_q;
								state_d = fqsd_pkg::S_POP;
							end
						end
						fqsd_pkg::REQ_QUERY, fqsd_pkg::REQ_DELETE: begin
							if (empty) begin
								res_load   = 1'b1;
								res_status = fqsd_pkg::STAT_NOT_FOUND;
							end else begin
								rd_pos_d = '0;
								state_d  = fqsd_pkg::S_SCAN;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			fqsd_pkg::S_POP: begin
				res_load = 1'b1;
				res_obj  = rdata;
				head_d   = head_inc;
				count_d  = count_q - CW'(1);
				state_d  = fqsd_pkg::S_IDLE;
			end
			fqsd_pkg::S_SCAN: begin
				if (issue) begin
					re       = 1'b1;
					raddr    = slot_of(head_q, rd_pos_q);
					rd_pos_d = rd_pos_q + CW'(1);
				end
				vld_d = issue;
				if (vld_s1 && (rdata == h_q)) begin
					if (req_q == fqsd_pkg::REQ_DELETE) begin
						rd_pos_d = pos_s1 + CW'(1);
						vld_d    = 1'b0;
						state_d  = fqsd_pkg::S_SHIFT;
					end else begin
						res_load  = 1'b1;
						res_found = 1'b1;
						state_d   = fqsd_pkg::S_IDLE;
					end
				end else if (!issue && !vld_s1) begin
					res_load   = 1'b1;
					res_status = fqsd_pkg::STAT_NOT_FOUND;
					state_d    = fqsd_pkg::S_IDLE;
				end
			end
			fqsd_pkg::S_SHIFT: begin
				if (issue) begin
					re       = 1'b1;
					raddr    = slot_of(head_q, rd_pos_q);
					rd_pos_d = rd_pos_q + CW'(1);
				end
				vld_d = issue;
				if (vld_s1) begin
					we    = 1'b1;
					waddr = slot_of(head_q, pos_s1 - CW'(1));
					wdata = rdata;
				end
				if (!issue && !vld_s1) begin
					res_load  = 1'b1;
					res_found = 1'b1;
					count_d   = count_q - CW'(1);
					state_d   = fqsd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fqsd_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fqsd_pkg::S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			rd_pos_q <= '0;
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			rd_pos_q <= rd_pos_d;
			vld_s1   <= vld_d;
			done_q   <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= rd_pos_q;
		if (accept) begin
			req_q <= req_type;
			h_q   <= obj_value;
		end
		if (res_load) begin
			obj_out_q <= res_obj;
			status_q  <= res_status;
			found_q   <= res_found;
			len_q     <= count_d;
			empty_q   <= (count_d == '0);
		end
	end

	assign busy         = (state_q != fqsd_pkg::S_IDLE);
	assign done         = done_q;
	assign obj_out      = obj_out_q;
	assign status       = status_q;
	assign found        = found_q;
	assign queue_length = len_q;
	assign is_empty     = empty_q;

endmodule

// ===== sv/fqsd_mem.sv =====
// Entry memory: one write port, one read port with registered read data.
module fqsd_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/fqsd_checker.sv =====
// Port-level checks for the handle queue and their binding to the top level.
module fqsd_checker #(
	parameter int CAPACITY    = 16,
	parameter int HANDLE_BITS = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [HANDLE_BITS-1:0]        obj_out,
	input logic [1:0]                    status,
	input logic                          found,
	input logic [$clog2(CAPACITY+1)-1:0] queue_length,
	input logic                          is_empty
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is still in work");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (queue_length == '0)))
		else $error("empty flag disagrees with length");

	a_req_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither in work nor answered");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != fqsd_pkg::STAT_OK)) |-> ((obj_out == '0) && !found))
		else $error("refused request carries a handle or a match");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request work ended without a result");

endmodule

bind fifo_queue_search_delete fqsd_checker #(
	.CAPACITY   (CAPACITY),
	.HANDLE_BITS(HANDLE_BITS)
) u_fqsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.obj_out     (obj_out),
	.status      (status),
	.found       (found),
	.queue_length(queue_length),
	.is_empty    (is_empty)
);

// ===== tb/tb_fifo_queue_search_delete.sv =====
// Testbench for the handle queue with append, insert, remove, query and delete by key.
module tb_fifo_queue_search_delete;

	localparam int CAPACITY = 16;
	localparam int HANDLE_BITS = 32;
	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int RANDOM_REQUESTS = 750;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REQ_SPARE_MID = 3'd6;
	localparam logic [2:0] REQ_SPARE_LAST = 3'd7;

	typedef struct {
		logic [2:0]             code;
		logic [HANDLE_BITS-1:0] handle;
		bit                     drain;
	} request_t;

	typedef struct {
		logic [HANDLE_BITS-1:0] obj;
		fqsd_pkg::status_t      stat;
		logic                   hit;
		logic [LEN_W-1:0]       len;
		logic                   empty;
	} answer_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [2:0]             req_type = fqsd_pkg::REQ_APPEND;
	logic [HANDLE_BITS-1:0] obj_value = '0;
	logic                   done;
	logic [HANDLE_BITS-1:0] obj_out;
	logic [1:0]             status;
	logic                   found;
	logic [LEN_W-1:0]       queue_length;
	logic                   is_empty;

	request_t               request_q[$];
	answer_t                answer_q[$];
	logic [HANDLE_BITS-1:0] held_handles[$];
	answer_t                due;
	int                     sent_cnt = 0;
	int                     fail_cnt = 0;
	int                     cycle_cnt = 0;

	fifo_queue_search_delete #(
		.CAPACITY(CAPACITY),
		.HANDLE_BITS(HANDLE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.obj_value(obj_value),
		.done(done),
		.obj_out(obj_out),
		.status(status),
		.found(found),
		.queue_length(queue_length),
		.is_empty(is_empty)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic answer_t apply_request(logic [2:0] code, logic [HANDLE_BITS-1:0] handle);
		answer_t r;
		int pos;
		r.obj = '0;
		r.stat = fqsd_pkg::STAT_OK;
		r.hit = 1'b0;
		pos = -1;
		for (int i = 0; i < held_handles.size(); i++) begin
			if (pos < 0 && held_handles[i] == handle) begin
				pos = i;
			end
		end
		case (code)
			fqsd_pkg::REQ_APPEND: begin
				if (held_handles.size() >= CAPACITY) r.stat = fqsd_pkg::STAT_FULL;
				else held_handles.push_back(handle);
			end
			fqsd_pkg::REQ_INSERT: begin
				if (held_handles.size() >= CAPACITY) r.stat = fqsd_pkg::STAT_FULL;
				else held_handles.push_front(handle);
			end
			fqsd_pkg::REQ_REMOVE: begin
				if (held_handles.size() == 0) r.stat = fqsd_pkg::STAT_EMPTY;
				else r.obj = held_handles.pop_front();
			end
			fqsd_pkg::REQ_QUERY: begin
				if (pos >= 0) r.hit = 1'b1;
				else r.stat = fqsd_pkg::STAT_NOT_FOUND;
			end
			fqsd_pkg::REQ_DELETE: begin
				if (pos >= 0) begin
					held_handles.delete(pos);
					r.hit = 1'b1;
				end else begin
					r.stat = fqsd_pkg::STAT_NOT_FOUND;
				end
			end
			default: ;
		endcase
		r.len = LEN_W'(held_handles.size());
		r.empty = (held_handles.size() == 0);
		return r;
	endfunction

	task automatic add_request(logic [2:0] code, logic [HANDLE_BITS-1:0] handle);
		request_t q;
		q.code = code;
		q.handle = handle;
		q.drain = 1'b0;
		request_q.push_back(q);
	endtask

	task automatic add_drain_pause();
		request_t q;
		q.code = fqsd_pkg::REQ_APPEND;
		q.handle = '0;
		q.drain = 1'b1;
		request_q.push_back(q);
	endtask

	// drive requests; hold start until busy is low
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				answer_q.push_back(apply_request(req_type, obj_value));
				sent_cnt++;
			end
			if (!start || !busy) begin
				if (request_q.size() != 0 && request_q[0].drain) begin
					if (answer_q.size() == 0) request_q.delete(0);
					start <= 1'b0;
				end else if (request_q.size() != 0 &&
						((sent_cnt >= 300 && sent_cnt < 480) || $urandom_range(0, 99) >= 11)) begin
					start <= 1'b1;
					req_type <= request_q[0].code;
					obj_value <= request_q[0].handle;
					request_q.delete(0);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				$error("result with no request outstanding: obj_out %h status %0d", obj_out, status);
				fail_cnt++;
			end else begin
				due = answer_q.pop_front();
				if (obj_out !== due.obj) begin
					$error("obj_out: expected %h, got %h", due.obj, obj_out);
					fail_cnt++;
				end
				if (status !== due.stat) begin
					$error("status: expected %0d, got %0d", due.stat, status);
					fail_cnt++;
				end
				if (found !== due.hit) begin
					$error("found: expected %0d, got %0d", due.hit, found);
					fail_cnt++;
				end
				if (queue_length !== due.len) begin
					$error("queue_length: expected %0d, got %0d", due.len, queue_length);
					fail_cnt++;
				end
				if (is_empty !== due.empty) begin
					$error("is_empty: expected %0d, got %0d", due.empty, is_empty);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [HANDLE_BITS-1:0] pool[8];
		logic [HANDLE_BITS-1:0] handle;
		logic [2:0]             code;
		int                     made;
		int                     chunk;
		int                     mode;
		int                     roll;

		add_request(fqsd_pkg::REQ_REMOVE, 32'h1234_5678);
		add_request(fqsd_pkg::REQ_QUERY, 32'h0000_0000);
		add_request(fqsd_pkg::REQ_DELETE, 32'h0000_0000);
		add_request(REQ_SPARE_FIRST, 32'hFFFF_FFFF);
		add_request(REQ_SPARE_MID, 32'h0000_0000);
		add_request(REQ_SPARE_LAST, 32'hA5A5_A5A5);
		add_request(fqsd_pkg::REQ_APPEND, 32'h0000_0000);
		add_request(fqsd_pkg::REQ_APPEND, 32'hFFFF_FFFF);
		add_request(fqsd_pkg::REQ_INSERT, 32'h8000_0000);
		add_request(fqsd_pkg::REQ_APPEND, 32'h5A5A_5A5A);
		add_request(fqsd_pkg::REQ_APPEND, 32'h0000_0000);
		add_request(fqsd_pkg::REQ_QUERY, 32'hFFFF_FFFF);
		add_request(fqsd_pkg::REQ_QUERY, 32'h1234_5678);
		add_request(fqsd_pkg::REQ_DELETE, 32'h0000_0000);
		add_request(fqsd_pkg::REQ_DELETE, 32'h5A5A_5A5A);
		add_request(fqsd_pkg::REQ_DELETE, 32'h0000_0000);
		add_request(fqsd_pkg::REQ_DELETE, 32'h8000_0000);
		add_request(REQ_SPARE_LAST, 32'h0000_0001);
		add_request(fqsd_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
		add_request(fqsd_pkg::REQ_REMOVE, 32'h0000_0000);
		add_request(fqsd_pkg::REQ_INSERT, 32'h7FFF_FFFF);
		add_request(fqsd_pkg::REQ_DELETE, 32'h7FFF_FFFF);
		add_drain_pause();

		foreach (pool[k]) pool[k] = $urandom;
		pool[0] = '0;
		pool[1] = '1;
		made = 0;
		chunk = 0;
		while (made < RANDOM_REQUESTS) begin
			mode = chunk % 3;
			pool[3'($urandom_range(2, 7))] = $urandom;
			for (int n = 0; n < 40; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					code = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
				end else begin
					roll = $urandom_range(0, 99);
					case (mode)
						0: code = roll < 45 ? fqsd_pkg::REQ_APPEND :
							roll < 75 ? fqsd_pkg::REQ_INSERT :
							roll < 83 ? fqsd_pkg::REQ_REMOVE :
							roll < 91 ? fqsd_pkg::REQ_QUERY : fqsd_pkg::REQ_DELETE;
						1: code = roll < 15 ? fqsd_pkg::REQ_APPEND :
							roll < 25 ? fqsd_pkg::REQ_INSERT :
							roll < 65 ? fqsd_pkg::REQ_REMOVE :
							roll < 82 ? fqsd_pkg::REQ_QUERY : fqsd_pkg::REQ_DELETE;
						default: code = roll < 28 ? fqsd_pkg::REQ_APPEND :
							roll < 46 ? fqsd_pkg::REQ_INSERT :
							roll < 64 ? fqsd_pkg::REQ_REMOVE :
							roll < 82 ? fqsd_pkg::REQ_QUERY : fqsd_pkg::REQ_DELETE;
					endcase
					made++;
				end
				roll = $urandom_range(0, 99);
				if (roll < 60) handle = pool[3'($urandom_range(0, 7))];
				else if (roll < 90) handle = $urandom;
				else handle = roll[0] ? '1 : '0;
				add_request(code, handle);
			end
			chunk++;
			if (chunk == 9) add_drain_pause();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (request_q.size() != 0 || start || answer_q.size() != 0) @(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/fqsd_pkg.sv
sv/fqsd_mem.sv
sv/fifo_queue_search_delete.sv
sv/fqsd_checker.sv
tb/tb_fifo_queue_search_delete.sv
